// ===== hw/rtl/lmd_pkg.sv =====
// Shared types and constants for the 3x3 local minimum detector.
`timescale 1ns / 1ps

package lmd_pkg;

    // Frame size registers and reported positions are 11 bits wide.
    localparam int POS_W = 11;

    // Configuration register index width and register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = 2'd1;

    // Smallest legal frame dimension.
    localparam logic [POS_W-1:0] MIN_DIM = 11'd2;

    // Report slots per input item: (r-1,c-1), (r-1,c), (r,c-1), (r,c).
    localparam int NUM_SLOTS = 4;

    // Which neighbor directions of a center lie inside the frame.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } nbr_ok_t;

endpackage

// ===== hw/rtl/lmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lmd_center_check.sv =====
// Strict minimum test of one window center against its in-frame neighbors.
`timescale 1ns / 1ps

module lmd_center_check import lmd_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int WR = 1,
    parameter int WC = 1
) (
    input  logic signed [SAMPLE_BITS-1:0] win [9],
    input  nbr_ok_t                       nbr_ok,
    output logic                          is_min
);

    always_comb begin
        logic ok;
        logic row_ok;
        logic col_ok;
        logic in_win;
        int   nr;
        int   nc;
        ok = 1'b1;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                nr     = WR + dr - 1;
                nc     = WC + dc - 1;
                in_win = (nr >= 0) && (nr <= 2) && (nc >= 0) && (nc <= 2);
                row_ok = (dr == 0) ? nbr_ok.top  : ((dr == 2) ? nbr_ok.bottom : 1'b1);
                col_ok = (dc == 0) ? nbr_ok.left : ((dc == 2) ? nbr_ok.right  : 1'b1);
                if (!(dr == 1 && dc == 1) && in_win && row_ok && col_ok) begin
                    // equal neighbor blocks the report
                    if (!(win[in_win ? nr * 3 + nc : 0] > win[WR * 3 + WC])) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        is_min = ok;
    end

endmodule

// ===== hw/rtl/local_minimum_detector_3x3.sv =====
// Top level: streaming strict 3x3 local minimum detector with line buffers.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: sample
//  m_        out  m_tvalid/m_tready  m_tdata: min_value, min_row, min_col; m_tlast
//  cfg_      in   cfg_we             cfg_addr: register index, cfg_wdata: value
//
//  One sample per cycle when no reports are waiting; a sample passes the input
//  stage, then the result slots. Each sample yields 0..4 reports, drained one per
//  cycle from the result slots while m_tready is high; the input stage holds while
//  slots owe more than the report leaving this cycle. Reset (aresetn, synchronous)
//  sets a 2x2 frame at row 1, column 1; line buffers need no clearing pass.
`timescale 1ns / 1ps

module local_minimum_detector_3x3 import lmd_pkg::*; #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 2 * POS_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // min_value, min_row, min_col, zero pad
    output logic                  m_tlast,   // last_of_run

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [POS_W-1:0]      cfg_wdata
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PAD_W = M_TDATA_W - SAMPLE_BITS - 2 * POS_W;

    // ---------------- frame size and raster position ----------------
    logic [POS_W-1:0] frame_rows_reg, frame_rows_next;
    logic [POS_W-1:0] frame_cols_reg, frame_cols_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;

    logic s_xfer;
    logic m_xfer;
    logic acc_last_col;
    logic acc_last_row;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    assign acc_last_col = (32'(col_cnt_reg) + 32'd1) == 32'(frame_cols_reg);
    assign acc_last_row = (32'(row_cnt_reg) + 32'd1) == 32'(frame_rows_reg);

    always_comb begin
        frame_rows_next = frame_rows_reg;
        frame_cols_next = frame_cols_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        if (cfg_we && (cfg_addr == REG_FRAME_ROWS || cfg_addr == REG_FRAME_COLS)) begin
            // any size write restarts the frame; sizes saturate to the legal range
            if (cfg_addr == REG_FRAME_ROWS) begin
                if (cfg_wdata < MIN_DIM) begin
                    frame_rows_next = MIN_DIM;
                end else if (32'(cfg_wdata) > MAX_ROWS) begin
                    frame_rows_next = POS_W'(MAX_ROWS);
                end else begin
                    frame_rows_next = cfg_wdata;
                end
            end else begin
                if (cfg_wdata < MIN_DIM) begin
                    frame_cols_next = MIN_DIM;
                end else if (32'(cfg_wdata) > MAX_COLS) begin
                    frame_cols_next = POS_W'(MAX_COLS);
                end else begin
                    frame_cols_next = cfg_wdata;
                end
            end
            row_cnt_next = '0;
            col_cnt_next = '0;
        end else if (s_xfer) begin
            if (acc_last_col) begin
                col_cnt_next = '0;
                row_cnt_next = acc_last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end else begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= MIN_DIM;
            frame_cols_reg <= MIN_DIM;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
        end else begin
            frame_rows_reg <= frame_rows_next;
            frame_cols_reg <= frame_cols_next;
            row_cnt_reg    <= row_cnt_next;
            col_cnt_reg    <= col_cnt_next;
        end
    end

    // ---------------- input stage: sample + position, line buffer read ----------------
    logic                          p1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] p1_sample_reg;
    logic [ROW_W-1:0]              p1_row_reg;
    logic [COL_W-1:0]              p1_col_reg;
    logic                          p1_move;
    logic                          pend_free;

    // input stage empties into the result slots only when they free up this cycle
    assign p1_move  = p1_valid_reg && pend_free;
    assign s_tready = !p1_valid_reg || p1_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p1_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            p1_row_reg    <= row_cnt_reg;
            p1_col_reg    <= col_cnt_reg;
        end
    end

    logic [SAMPLE_BITS-1:0] above_rd;
    logic [SAMPLE_BITS-1:0] two_above_rd;

    // Between size writes, consecutive samples hit different columns, so the write
    // of one sample never meets the read of the next at the same address.
    lmd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_line_above (
        .aclk    (aclk),
        .wr_en   (p1_move),
        .wr_addr (p1_col_reg),
        .wr_data (p1_sample_reg),
        .rd_en   (s_xfer),
        .rd_addr (col_cnt_reg),
        .rd_data (above_rd)
    );

    lmd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_line_two_above (
        .aclk    (aclk),
        .wr_en   (p1_move),
        .wr_addr (p1_col_reg),
        .wr_data (above_rd),
        .rd_en   (s_xfer),
        .rd_addr (col_cnt_reg),
        .rd_data (two_above_rd)
    );

    // ---------------- 3x3 window ----------------
    // win index = row*3 + col; row 2 is the current line, col 2 the newest column.
    logic signed [SAMPLE_BITS-1:0] win_reg  [9];
    logic signed [SAMPLE_BITS-1:0] win_next [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i * 3 + 0] = win_reg[i * 3 + 1];
            win_next[i * 3 + 1] = win_reg[i * 3 + 2];
        end
        win_next[2] = two_above_rd;
        win_next[5] = above_rd;
        win_next[8] = p1_sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            win_reg <= win_next;
        end
    end

    // ---------------- neighbor masks and minimum tests ----------------
    logic r_ge1, r_ge2, c_ge1, c_ge2, last_row, last_col;

    assign r_ge1    = p1_row_reg != '0;
    assign r_ge2    = 32'(p1_row_reg) >= 32'd2;
    assign c_ge1    = p1_col_reg != '0;
    assign c_ge2    = 32'(p1_col_reg) >= 32'd2;
    assign last_row = (32'(p1_row_reg) + 32'd1) == 32'(frame_rows_reg);
    assign last_col = (32'(p1_col_reg) + 32'd1) == 32'(frame_cols_reg);

    nbr_ok_t nbr_ok [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_min;
    logic [NUM_SLOTS-1:0] slot_due;
    logic [NUM_SLOTS-1:0] slot_hit;

    // centers one row up sit at row r-1; centers on the current row at row r
    assign nbr_ok[0] = '{top: r_ge2, bottom: 1'b1,      left: c_ge2, right: 1'b1};
    assign nbr_ok[1] = '{top: r_ge2, bottom: 1'b1,      left: c_ge1, right: !last_col};
    assign nbr_ok[2] = '{top: r_ge1, bottom: !last_row, left: c_ge2, right: 1'b1};
    assign nbr_ok[3] = '{top: r_ge1, bottom: !last_row, left: c_ge1, right: !last_col};

    // a center is due once its whole window has arrived
    assign slot_due[0] = r_ge1 && c_ge1;
    assign slot_due[1] = r_ge1 && last_col;
    assign slot_due[2] = last_row && c_ge1;
    assign slot_due[3] = last_row && last_col;
    assign slot_hit    = slot_due & slot_min;

    lmd_center_check #(.SAMPLE_BITS(SAMPLE_BITS), .WR(1), .WC(1)) u_chk_up_left (
        .win (win_next), .nbr_ok (nbr_ok[0]), .is_min (slot_min[0])
    );
    lmd_center_check #(.SAMPLE_BITS(SAMPLE_BITS), .WR(1), .WC(2)) u_chk_up (
        .win (win_next), .nbr_ok (nbr_ok[1]), .is_min (slot_min[1])
    );
    lmd_center_check #(.SAMPLE_BITS(SAMPLE_BITS), .WR(2), .WC(1)) u_chk_left (
        .win (win_next), .nbr_ok (nbr_ok[2]), .is_min (slot_min[2])
    );
    lmd_center_check #(.SAMPLE_BITS(SAMPLE_BITS), .WR(2), .WC(2)) u_chk_here (
        .win (win_next), .nbr_ok (nbr_ok[3]), .is_min (slot_min[3])
    );

    // ---------------- result slots ----------------
    // Slot k reports at row base + k[1], column base + k[0] (1-based).
    logic [NUM_SLOTS-1:0]          pend_mask_reg, pend_mask_next;
    logic signed [SAMPLE_BITS-1:0] pend_val_reg [NUM_SLOTS];
    logic [POS_W-1:0]              pend_row_reg;
    logic [POS_W-1:0]              pend_col_reg;
    logic [NUM_SLOTS-1:0]          sel_onehot;
    logic [1:0]                    sel_idx;

    always_comb begin
        sel_onehot = '0;
        sel_idx    = 2'd0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (pend_mask_reg[k]) begin
                sel_onehot = NUM_SLOTS'(1) << k;
                sel_idx    = 2'(k);
            end
        end
    end

    assign m_tvalid  = pend_mask_reg != '0;
    assign m_tlast   = (pend_mask_reg & ~sel_onehot) == '0;
    assign pend_free = !m_tvalid || (m_tready && m_tlast);

    always_comb begin
        pend_mask_next = pend_mask_reg;
        if (p1_move) begin
            pend_mask_next = slot_hit;
        end else if (m_xfer) begin
            pend_mask_next = pend_mask_reg & ~sel_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_mask_reg <= '0;
        end else begin
            pend_mask_reg <= pend_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            pend_val_reg[0] <= win_next[4];
            pend_val_reg[1] <= win_next[5];
            pend_val_reg[2] <= win_next[7];
            pend_val_reg[3] <= win_next[8];
            pend_row_reg    <= POS_W'(p1_row_reg);
            pend_col_reg    <= POS_W'(p1_col_reg);
        end
    end

    assign m_tdata = {
        {PAD_W{1'b0}},
        pend_col_reg + POS_W'(sel_idx[0]),
        pend_row_reg + POS_W'(sel_idx[1]),
        pend_val_reg[sel_idx]
    };

`ifndef SYNTHESIS
    // raster position never leaves the configured frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(col_cnt_reg) < 32'(frame_cols_reg)) && (32'(row_cnt_reg) < 32'(frame_rows_reg)))
        else $error("raster position outside frame");

    // a stalled input stage keeps its item and its column
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_move) |=> (p1_valid_reg && $stable(p1_col_reg)))
        else $error("input stage lost a stalled item");

    // after the final report of a sample, slots are empty unless a new sample moved in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> ((pend_mask_reg == '0) || $past(p1_move)))
        else $error("result slots not drained after final report");
`endif

endmodule
